// ===== design/vrt_pkg.sv =====
package vrt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int PAGE_BITS_DEF     = 12;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_FIND   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_FULL      = 3'd1,
        STATUS_NOT_FOUND = 3'd2,
        STATUS_TOO_LARGE = 3'd3,
        STATUS_ZERO_LEN  = 3'd4,
        STATUS_NO_SPACE  = 3'd5
    } status_t;

    localparam logic [1:0] KIND_FREE   = 2'd0;
    localparam logic [1:0] KIND_ANON   = 2'd1;
    localparam logic [1:0] KIND_BINARY = 2'd2;

    localparam logic [11:0] USER_BIT = 12'h004;

    localparam logic [1:0] CFG_MERGE_EN     = 2'd0;
    localparam logic [1:0] CFG_SEARCH_START = 2'd1;
    localparam logic [1:0] CFG_SEARCH_END   = 2'd2;

    localparam logic [31:0] SEARCH_START_RST = 32'h0080_0000;
    localparam logic [31:0] SEARCH_END_RST   = 32'hEEBF_E000;

endpackage

// ===== design/virtual_region_table_core.sv =====
// Region table engine: keeps up to TABLE_ENTRIES address regions (kind, base,
// length, permission, two tags) and serves one request at a time.
//
// Input channel (s_*): valid/ready; a transfer carries func, address, length,
// perm, header_ref and binary_ref. s_ready is high only while the sequencer
// is idle. Result channel (m_*): valid/ready; one transfer per request with
// status, slot and found_address, held in an output register. The next
// request can be taken while a result still waits in that register.
//
// Run time is set by the table walks. A visited live entry is read from
// memory, then compared; a free entry is skipped.
//   lookup:     one table walk
//   remove:     one table walk, plus a free-slot walk and insert on a split
//   insert:     a free-slot walk, plus one merge round if enabled; a merge
//               round walks all pairs of live entries
//   find-space: one table walk per region or gap stepped over
// Reset clears the kind flops (all slots free) and restores the config
// registers; the other table fields need no clearing. If the receiver stalls
// the result sits in the output register; a later finished result waits, with
// the sequencer in its last state, until the register frees up.
// Config writes (cfg_wr_en/cfg_index/cfg_wdata) take effect immediately and
// are expected only while the engine is idle.
module virtual_region_table_core #(
    parameter int TABLE_ENTRIES = vrt_pkg::TABLE_ENTRIES_DEF,
    parameter int PAGE_BITS     = vrt_pkg::PAGE_BITS_DEF,
    localparam int IW           = $clog2(TABLE_ENTRIES)
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_wdata,

    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_func,
    input  logic [31:0]   s_address,
    input  logic [31:0]   s_length,
    input  logic [11:0]   s_perm,
    input  logic [31:0]   s_header_ref,
    input  logic [31:0]   s_binary_ref,

    output logic          m_valid,
    input  logic          m_ready,
    output logic [2:0]    m_status,
    output logic [IW-1:0] m_slot,
    output logic [31:0]   m_found_address
);

    localparam int CW = IW + 1;     // counters reach TABLE_ENTRIES
    localparam int AW = 34;         // find-space cursor arithmetic
    localparam logic [CW-1:0] LAST   = CW'(TABLE_ENTRIES);
    localparam logic [AW-1:0] PG_MSK = AW'((64'd1 << PAGE_BITS) - 64'd1);
    localparam logic [AW-1:0] PG     = AW'(64'd1 << PAGE_BITS);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_FREE     = 14'b00000000000010,
        S_SPLIT_WR = 14'b00000000000100,
        S_INS_WR   = 14'b00000000001000,
        S_MO_RD    = 14'b00000000010000,
        S_MO_CAP   = 14'b00000000100000,
        S_MI_RD    = 14'b00000001000000,
        S_MI_CMP   = 14'b00000010000000,
        S_SCAN_RD  = 14'b00000100000000,
        S_SCAN_CMP = 14'b00001000000000,
        S_SCAN_END = 14'b00010000000000,
        S_FS_STEP  = 14'b00100000000000,
        S_FS_CHECK = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // config
    logic        merge_en_reg;
    logic [31:0] search_start_reg, search_end_reg;

    // table: kind in flops (reset), the rest in memories
    logic [1:0]  kind_reg [TABLE_ENTRIES];
    logic [31:0] base_mem [TABLE_ENTRIES];
    logic [31:0] len_mem  [TABLE_ENTRIES];
    logic [11:0] perm_mem [TABLE_ENTRIES];
    logic [31:0] htag_mem [TABLE_ENTRIES];
    logic [31:0] btag_mem [TABLE_ENTRIES];
    logic [31:0] rd_base_reg, rd_len_reg, rd_htag_reg, rd_btag_reg;
    logic [11:0] rd_perm_reg;
    logic [IW-1:0] raddr;

    // memory and kind write port
    logic          we_base, we_len, we_attr, kind_we;
    logic [IW-1:0] mem_wa, kind_wa;
    logic [31:0]   wd_base, wd_len;
    logic [1:0]    kind_wd;

    // request
    logic [1:0]  func_reg, func_next;
    logic [31:0] addr_reg, addr_next, rlen_reg, rlen_next;
    logic [32:0] qend_reg, qend_next;

    // insert operands (request or right part of a split)
    logic [31:0] ins_base_reg, ins_base_next, ins_len_reg, ins_len_next;
    logic [11:0] ins_perm_reg, ins_perm_next;
    logic [31:0] ins_htag_reg, ins_htag_next, ins_btag_reg, ins_btag_next;
    logic [1:0]  ins_kind_reg, ins_kind_next;

    logic [CW-1:0] idx_reg, idx_next, o_reg, o_next;
    logic [IW-1:0] free_reg, free_next;

    // merge outer entry
    logic [31:0] ol_reg, ol_next, olen_reg, olen_next;
    logic [32:0] orr_reg, orr_next;
    logic [11:0] operm_reg, operm_next;

    // hit of the current walk
    logic          hit_reg, hit_next;
    logic [IW-1:0] hit_slot_reg, hit_slot_next;
    logic [31:0]   hit_base_reg, hit_base_next, hit_len_reg, hit_len_next;
    logic [32:0]   hit_end_reg, hit_end_next;
    logic [11:0]   hit_perm_reg, hit_perm_next;
    logic [31:0]   hit_htag_reg, hit_htag_next, hit_btag_reg, hit_btag_next;

    // find-space
    logic [AW-1:0] cur_reg, cur_next, nb_reg, nb_next, need_reg, need_next;
    logic [AW-1:0] target_reg, target_next, run_reg, run_next, kp_reg, kp_next;

    // result
    logic [2:0]    status_reg, status_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [31:0]   found_reg, found_next;

    logic          m_valid_reg, m_valid_next;
    logic [2:0]    m_status_reg, m_status_next;
    logic [IW-1:0] m_slot_reg, m_slot_next;
    logic [31:0]   m_found_reg, m_found_next;

    // scratch
    logic [32:0]   sum33, end33;
    logic [AW-1:0] base34, diff34;

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_slot          = m_slot_reg;
    assign m_found_address = m_found_reg;

    assign raddr = (state_reg == S_MO_RD) ? o_reg[IW-1:0] : idx_reg[IW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            merge_en_reg     <= 1'b1;
            search_start_reg <= vrt_pkg::SEARCH_START_RST;
            search_end_reg   <= vrt_pkg::SEARCH_END_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                vrt_pkg::CFG_MERGE_EN:     merge_en_reg     <= cfg_wdata[0];
                vrt_pkg::CFG_SEARCH_START: search_start_reg <= cfg_wdata;
                vrt_pkg::CFG_SEARCH_END:   search_end_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                kind_reg[k] <= vrt_pkg::KIND_FREE;
            end
        end else if (kind_we) begin
            kind_reg[kind_wa] <= kind_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (we_base) begin
            base_mem[mem_wa] <= wd_base;
        end
        if (we_len) begin
            len_mem[mem_wa] <= wd_len;
        end
        if (we_attr) begin
            perm_mem[mem_wa] <= ins_perm_reg;
            htag_mem[mem_wa] <= ins_htag_reg;
            btag_mem[mem_wa] <= ins_btag_reg;
        end
        rd_base_reg <= base_mem[raddr];
        rd_len_reg  <= len_mem[raddr];
        rd_perm_reg <= perm_mem[raddr];
        rd_htag_reg <= htag_mem[raddr];
        rd_btag_reg <= btag_mem[raddr];
    end

    always_comb begin
        state_next    = state_reg;
        func_next     = func_reg;
        addr_next     = addr_reg;
        rlen_next     = rlen_reg;
        qend_next     = qend_reg;
        ins_base_next = ins_base_reg;
        ins_len_next  = ins_len_reg;
        ins_perm_next = ins_perm_reg;
        ins_htag_next = ins_htag_reg;
        ins_btag_next = ins_btag_reg;
        ins_kind_next = ins_kind_reg;
        idx_next      = idx_reg;
        o_next        = o_reg;
        free_next     = free_reg;
        ol_next       = ol_reg;
        olen_next     = olen_reg;
        orr_next      = orr_reg;
        operm_next    = operm_reg;
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        hit_base_next = hit_base_reg;
        hit_len_next  = hit_len_reg;
        hit_end_next  = hit_end_reg;
        hit_perm_next = hit_perm_reg;
        hit_htag_next = hit_htag_reg;
        hit_btag_next = hit_btag_reg;
        cur_next      = cur_reg;
        nb_next       = nb_reg;
        need_next     = need_reg;
        target_next   = target_reg;
        run_next      = run_reg;
        kp_next       = kp_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        found_next    = found_reg;
        m_valid_next  = m_valid_reg & ~m_ready;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        m_found_next  = m_found_reg;

        we_base = 1'b0;
        we_len  = 1'b0;
        we_attr = 1'b0;
        mem_wa  = free_reg;
        wd_base = ins_base_reg;
        wd_len  = ins_len_reg;
        kind_we = 1'b0;
        kind_wa = free_reg;
        kind_wd = ins_kind_reg;

        sum33  = '0;
        end33  = '0;
        base34 = '0;
        diff34 = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next     = s_func;
                    addr_next     = s_address;
                    rlen_next     = s_length;
                    qend_next     = {1'b0, s_address} + {1'b0, s_length};
                    ins_base_next = s_address;
                    ins_len_next  = s_length;
                    ins_perm_next = s_perm | vrt_pkg::USER_BIT;
                    ins_htag_next = s_header_ref;
                    ins_btag_next = s_binary_ref;
                    ins_kind_next = (s_binary_ref == '0) ? vrt_pkg::KIND_ANON
                                                         : vrt_pkg::KIND_BINARY;
                    status_next   = vrt_pkg::STATUS_OK;
                    slot_next     = '0;
                    found_next    = '0;
                    idx_next      = '0;
                    hit_next      = 1'b0;
                    nb_next       = {2'b0, search_end_reg};
                    cur_next      = {2'b0, s_address};
                    unique case (s_func)
                        vrt_pkg::FUNC_INSERT: begin
                            if (s_length == '0) begin
                                status_next = vrt_pkg::STATUS_ZERO_LEN;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_FREE;
                            end
                        end
                        vrt_pkg::FUNC_REMOVE: begin
                            if (s_length == '0) begin
                                status_next = vrt_pkg::STATUS_ZERO_LEN;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        vrt_pkg::FUNC_LOOKUP: state_next = S_SCAN_RD;
                        vrt_pkg::FUNC_FIND: begin
                            // zero length counts as one page
                            need_next   = (s_length == '0) ? PG
                                        : (({2'b0, s_length} + PG_MSK) & ~PG_MSK);
                            cur_next    = {2'b0, search_start_reg};
                            target_next = {2'b0, search_start_reg};
                            run_next    = '0;
                            state_next  = S_FS_CHECK;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            // first free slot, one entry a cycle
            S_FREE: begin
                if (idx_reg == LAST) begin
                    status_next = vrt_pkg::STATUS_FULL;
                    state_next  = S_DONE;
                end else if (kind_reg[idx_reg[IW-1:0]] == vrt_pkg::KIND_FREE) begin
                    free_next  = idx_reg[IW-1:0];
                    state_next = (func_reg == vrt_pkg::FUNC_INSERT) ? S_INS_WR
                                                                    : S_SPLIT_WR;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            // left part of a split keeps its slot
            S_SPLIT_WR: begin
                we_len     = 1'b1;
                mem_wa     = hit_slot_reg;
                wd_len     = addr_reg - hit_base_reg;
                state_next = S_INS_WR;
            end

            S_INS_WR: begin
                we_base = 1'b1;
                we_len  = 1'b1;
                we_attr = 1'b1;
                kind_we = 1'b1;
                if (func_reg == vrt_pkg::FUNC_INSERT) begin
                    slot_next = free_reg;
                end
                o_next     = '0;
                state_next = merge_en_reg ? S_MO_RD : S_DONE;
            end

            S_MO_RD: begin
                if (o_reg == LAST) begin
                    state_next = S_DONE;
                end else if (kind_reg[o_reg[IW-1:0]] == vrt_pkg::KIND_FREE) begin
                    o_next = o_reg + 1'b1;
                end else begin
                    state_next = S_MO_CAP;
                end
            end

            S_MO_CAP: begin
                ol_next    = rd_base_reg;
                olen_next  = rd_len_reg;
                orr_next   = {1'b0, rd_base_reg} + {1'b0, rd_len_reg};
                operm_next = rd_perm_reg;
                idx_next   = '0;
                state_next = S_MI_RD;
            end

            S_MI_RD: begin
                if (idx_reg == LAST) begin
                    o_next     = o_reg + 1'b1;
                    state_next = S_MO_RD;
                end else if (kind_reg[idx_reg[IW-1:0]] == vrt_pkg::KIND_FREE
                             || idx_reg == o_reg
                             || kind_reg[idx_reg[IW-1:0]] != kind_reg[o_reg[IW-1:0]]) begin
                    idx_next = idx_reg + 1'b1;
                end else begin
                    state_next = S_MI_CMP;
                end
            end

            S_MI_CMP: begin
                sum33 = {1'b0, olen_reg} + {1'b0, rd_len_reg};
                end33 = {1'b0, rd_base_reg} + {1'b0, rd_len_reg};
                idx_next   = idx_reg + 1'b1;
                state_next = S_MI_RD;
                if (rd_perm_reg == operm_reg && !sum33[32]) begin
                    if ({1'b0, rd_base_reg} == orr_reg) begin
                        // inner follows outer: outer grows
                        kind_we    = 1'b1;
                        kind_wa    = idx_reg[IW-1:0];
                        kind_wd    = vrt_pkg::KIND_FREE;
                        we_len     = 1'b1;
                        mem_wa     = o_reg[IW-1:0];
                        wd_len     = sum33[31:0];
                        o_next     = o_reg + 1'b1;
                        state_next = S_MO_RD;
                    end else if (end33 == {1'b0, ol_reg}) begin
                        // outer follows inner: inner grows
                        kind_we    = 1'b1;
                        kind_wa    = o_reg[IW-1:0];
                        kind_wd    = vrt_pkg::KIND_FREE;
                        we_len     = 1'b1;
                        mem_wa     = idx_reg[IW-1:0];
                        wd_len     = sum33[31:0];
                        o_next     = o_reg + 1'b1;
                        state_next = S_MO_RD;
                    end
                end
            end

            // walk for the slot holding cur; also tracks the lowest base above cur
            S_SCAN_RD: begin
                if (idx_reg == LAST) begin
                    state_next = S_SCAN_END;
                end else if (kind_reg[idx_reg[IW-1:0]] == vrt_pkg::KIND_FREE) begin
                    idx_next = idx_reg + 1'b1;
                end else begin
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP: begin
                end33  = {1'b0, rd_base_reg} + {1'b0, rd_len_reg};
                base34 = {2'b0, rd_base_reg};
                if (base34 <= cur_reg && {1'b0, end33} > cur_reg) begin
                    hit_next      = 1'b1;
                    hit_slot_next = idx_reg[IW-1:0];
                    hit_base_next = rd_base_reg;
                    hit_len_next  = rd_len_reg;
                    hit_end_next  = end33;
                    hit_perm_next = rd_perm_reg;
                    hit_htag_next = rd_htag_reg;
                    hit_btag_next = rd_btag_reg;
                    state_next    = S_SCAN_END;
                end else begin
                    if (base34 > cur_reg && base34 < nb_reg) begin
                        nb_next = base34;
                    end
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end

            S_SCAN_END: begin
                state_next = S_DONE;
                unique case (func_reg)
                    vrt_pkg::FUNC_LOOKUP: begin
                        if (hit_reg) begin
                            slot_next = hit_slot_reg;
                        end else begin
                            status_next = vrt_pkg::STATUS_NOT_FOUND;
                        end
                    end
                    vrt_pkg::FUNC_REMOVE: begin
                        mem_wa  = hit_slot_reg;
                        kind_wa = hit_slot_reg;
                        if (!hit_reg) begin
                            status_next = vrt_pkg::STATUS_NOT_FOUND;
                        end else if (qend_reg > hit_end_reg) begin
                            status_next = vrt_pkg::STATUS_TOO_LARGE;
                        end else if (hit_base_reg == addr_reg) begin
                            if (hit_len_reg == rlen_reg) begin
                                kind_we = 1'b1;
                                kind_wd = vrt_pkg::KIND_FREE;
                            end else begin
                                we_base = 1'b1;
                                we_len  = 1'b1;
                                wd_base = qend_reg[31:0];
                                wd_len  = hit_len_reg - rlen_reg;
                            end
                        end else if (qend_reg == hit_end_reg) begin
                            we_len = 1'b1;
                            wd_len = addr_reg - hit_base_reg;
                        end else begin
                            // split: right part goes in as a new region
                            ins_base_next = qend_reg[31:0];
                            ins_len_next  = 32'(hit_end_reg - qend_reg);
                            ins_perm_next = hit_perm_reg;
                            ins_htag_next = hit_htag_reg;
                            ins_btag_next = hit_btag_reg;
                            ins_kind_next = kind_reg[hit_slot_reg];
                            idx_next      = '0;
                            state_next    = S_FREE;
                        end
                    end
                    default: begin
                        diff34     = hit_reg ? ({1'b0, hit_end_reg} - cur_reg)
                                             : (nb_reg - cur_reg);
                        kp_next    = (diff34 + PG_MSK) & ~PG_MSK;
                        state_next = S_FS_STEP;
                    end
                endcase
            end

            S_FS_STEP: begin
                state_next = S_FS_CHECK;
                if (hit_reg) begin
                    cur_next    = cur_reg + kp_reg;
                    target_next = cur_reg + kp_reg;
                    run_next    = '0;
                end else if (run_reg + kp_reg >= need_reg) begin
                    found_next = target_reg[31:0];
                    state_next = S_DONE;
                end else begin
                    run_next = run_reg + kp_reg;
                    cur_next = cur_reg + kp_reg;
                end
            end

            S_FS_CHECK: begin
                if (cur_reg >= {2'b0, search_end_reg}) begin
                    status_next = vrt_pkg::STATUS_NO_SPACE;
                    state_next  = S_DONE;
                end else begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    nb_next    = {2'b0, search_end_reg};
                    state_next = S_SCAN_RD;
                end
            end

            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_slot_next   = slot_reg;
                    m_found_next  = found_reg;
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        addr_reg     <= addr_next;
        rlen_reg     <= rlen_next;
        qend_reg     <= qend_next;
        ins_base_reg <= ins_base_next;
        ins_len_reg  <= ins_len_next;
        ins_perm_reg <= ins_perm_next;
        ins_htag_reg <= ins_htag_next;
        ins_btag_reg <= ins_btag_next;
        ins_kind_reg <= ins_kind_next;
        idx_reg      <= idx_next;
        o_reg        <= o_next;
        free_reg     <= free_next;
        ol_reg       <= ol_next;
        olen_reg     <= olen_next;
        orr_reg      <= orr_next;
        operm_reg    <= operm_next;
        hit_reg      <= hit_next;
        hit_slot_reg <= hit_slot_next;
        hit_base_reg <= hit_base_next;
        hit_len_reg  <= hit_len_next;
        hit_end_reg  <= hit_end_next;
        hit_perm_reg <= hit_perm_next;
        hit_htag_reg <= hit_htag_next;
        hit_btag_reg <= hit_btag_next;
        cur_reg      <= cur_next;
        nb_reg       <= nb_next;
        need_reg     <= need_next;
        target_reg   <= target_next;
        run_reg      <= run_next;
        kp_reg       <= kp_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        found_reg    <= found_next;
        m_status_reg <= m_status_next;
        m_slot_reg   <= m_slot_next;
        m_found_reg  <= m_found_next;
    end

endmodule

// ===== design/vrt_checker.sv =====
module vrt_checker #(
    parameter int SW = 6
) (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input logic [2:0]    m_status,
    input logic [SW-1:0] m_slot,
    input logic [31:0]   m_found_address
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_slot)
                                && $stable(m_found_address))
        else $error("result changed while stalled");

    // one request at a time
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after a transfer");

    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= vrt_pkg::STATUS_NO_SPACE)
        else $error("bad status code");

    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != vrt_pkg::STATUS_OK |-> m_found_address == '0)
        else $error("address on a failed request");

    a_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == vrt_pkg::STATUS_FULL
                    || m_status == vrt_pkg::STATUS_ZERO_LEN
                    || m_status == vrt_pkg::STATUS_NO_SPACE) |-> m_slot == '0)
        else $error("slot on a failed request");

endmodule

bind virtual_region_table_core vrt_checker #(.SW(IW)) u_vrt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_slot          (m_slot),
    .m_found_address (m_found_address)
);

// ===== sim/virtual_region_table_checker.sv =====
module virtual_region_table_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_address,
    input  logic [31:0] s_length,
    input  logic [11:0] s_perm,
    input  logic [31:0] s_header_ref,
    input  logic [31:0] s_binary_ref,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [5:0]  m_slot,
    input  logic [31:0] m_found_address,
    output int          errors,
    output int          outstanding
);

    localparam int ENTRIES = vrt_pkg::TABLE_ENTRIES_DEF;
    localparam int PG_BITS = vrt_pkg::PAGE_BITS_DEF;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  slot;
        logic [31:0] found;
    } region_result_t;

    // shadow copy of the table and registers
    logic [1:0]  kind_q [ENTRIES];
    logic [31:0] base_q [ENTRIES];
    logic [31:0] len_q  [ENTRIES];
    logic [11:0] perm_q [ENTRIES];
    logic [31:0] htag_q [ENTRIES];
    logic [31:0] btag_q [ENTRIES];
    logic        merge_en_q;
    logic [31:0] scan_lo_q;
    logic [31:0] scan_hi_q;

    region_result_t pending_results[$];

    initial begin
        errors      = 0;
        outstanding = 0;
    end

    function automatic logic [32:0] end_at(int s);
        return {1'b0, base_q[s]} + {1'b0, len_q[s]};
    endfunction

    function automatic int holder(logic [32:0] a);
        for (int s = 0; s < ENTRIES; s++)
            if (kind_q[s] != vrt_pkg::KIND_FREE && {1'b0, base_q[s]} <= a && end_at(s) > a)
                return s;
        return -1;
    endfunction

    function automatic int first_free();
        for (int s = 0; s < ENTRIES; s++)
            if (kind_q[s] == vrt_pkg::KIND_FREE)
                return s;
        return -1;
    endfunction

    // one merge round: each live outer entry merges with at most one neighbor
    function automatic void merge_pass();
        logic [32:0] ol, orr, il, ir, sum;
        for (int o = 0; o < ENTRIES; o++) begin
            if (kind_q[o] == vrt_pkg::KIND_FREE)
                continue;
            ol  = {1'b0, base_q[o]};
            orr = end_at(o);
            for (int i = 0; i < ENTRIES; i++) begin
                if (kind_q[i] == vrt_pkg::KIND_FREE || i == o)
                    continue;
                if (kind_q[i] != kind_q[o] || perm_q[i] != perm_q[o])
                    continue;
                il  = {1'b0, base_q[i]};
                ir  = end_at(i);
                sum = {1'b0, len_q[o]} + {1'b0, len_q[i]};
                if (sum[32])
                    continue;
                if (il == orr) begin
                    kind_q[i] = vrt_pkg::KIND_FREE;
                    len_q[o] = sum[31:0];
                    break;
                end else if (ir == ol) begin
                    kind_q[o] = vrt_pkg::KIND_FREE;
                    len_q[i] = sum[31:0];
                    break;
                end
            end
        end
    endfunction

    function automatic logic [2:0] add_region(logic [31:0] base, logic [31:0] len,
                                              logic [11:0] perm, logic [31:0] htag,
                                              logic [31:0] btag, logic [1:0] kind,
                                              output int slot);
        int s;
        slot = 0;
        if (len == 0)
            return vrt_pkg::STATUS_ZERO_LEN;
        s = first_free();
        if (s < 0)
            return vrt_pkg::STATUS_FULL;
        kind_q[s] = kind;
        base_q[s] = base;
        len_q[s]  = len;
        perm_q[s] = perm | vrt_pkg::USER_BIT;
        htag_q[s] = htag;
        btag_q[s] = btag;
        slot = s;
        if (merge_en_q)
            merge_pass();
        return vrt_pkg::STATUS_OK;
    endfunction

    function automatic logic [2:0] cut_range(logic [31:0] a, logic [31:0] len);
        int s, unused;
        logic [32:0] rend, qend;
        logic [31:0] left;
        if (len == 0)
            return vrt_pkg::STATUS_ZERO_LEN;
        s = holder({1'b0, a});
        if (s < 0)
            return vrt_pkg::STATUS_NOT_FOUND;
        rend = end_at(s);
        qend = {1'b0, a} + {1'b0, len};
        if (qend > rend)
            return vrt_pkg::STATUS_TOO_LARGE;
        if (base_q[s] == a) begin
            if (len_q[s] == len) begin
                kind_q[s] = vrt_pkg::KIND_FREE;
            end else begin
                base_q[s] = a + len;
                len_q[s]  = len_q[s] - len;
            end
        end else if (qend == rend) begin
            len_q[s] = a - base_q[s];
        end else begin
            // split: right part re-enters as a fresh region
            left = a - base_q[s];
            if (first_free() < 0)
                return vrt_pkg::STATUS_FULL;
            len_q[s] = left;
            void'(add_region(qend[31:0], rend[31:0] - qend[31:0], perm_q[s],
                             htag_q[s], btag_q[s], kind_q[s], unused));
        end
        return vrt_pkg::STATUS_OK;
    endfunction

    function automatic logic [2:0] scan_free(logic [31:0] len, output logic [31:0] found);
        logic [63:0] pg, need, cur, lim, target, run, k, nb;
        int s;
        pg     = 64'd1 << PG_BITS;
        need   = (len == 0) ? pg : (((64'(len) + pg - 1) >> PG_BITS) << PG_BITS);
        cur    = 64'(scan_lo_q);
        lim    = 64'(scan_hi_q);
        target = cur;
        run    = 0;
        found  = 0;
        while (cur < lim) begin
            s = holder(cur[32:0]);
            if (s >= 0) begin
                k = (64'(end_at(s)) - cur + pg - 1) >> PG_BITS;
                cur = cur + (k << PG_BITS);
                target = cur;
                run = 0;
            end else begin
                nb = lim;
                for (int t = 0; t < ENTRIES; t++)
                    if (kind_q[t] != vrt_pkg::KIND_FREE && 64'(base_q[t]) > cur
                        && 64'(base_q[t]) < nb)
                        nb = 64'(base_q[t]);
                k = (nb - cur + pg - 1) >> PG_BITS;
                if (run + (k << PG_BITS) >= need) begin
                    found = target[31:0];
                    return vrt_pkg::STATUS_OK;
                end
                run = run + (k << PG_BITS);
                cur = cur + (k << PG_BITS);
            end
        end
        return vrt_pkg::STATUS_NO_SPACE;
    endfunction

    function automatic region_result_t predict_request(vrt_pkg::func_t f, logic [31:0] addr,
                                                      logic [31:0] len, logic [11:0] perm,
                                                      logic [31:0] htag, logic [31:0] btag);
        region_result_t r;
        int slot, s;
        logic [31:0] found;
        r = '0;
        case (f)
            vrt_pkg::FUNC_INSERT: begin
                r.status = add_region(addr, len, perm, htag, btag,
                                      (btag == 0) ? vrt_pkg::KIND_ANON
                                                  : vrt_pkg::KIND_BINARY, slot);
                if (r.status == vrt_pkg::STATUS_OK)
                    r.slot = slot[5:0];
            end
            vrt_pkg::FUNC_REMOVE: r.status = cut_range(addr, len);
            vrt_pkg::FUNC_LOOKUP: begin
                s = holder({1'b0, addr});
                if (s < 0)
                    r.status = vrt_pkg::STATUS_NOT_FOUND;
                else
                    r.slot = s[5:0];
            end
            default: begin
                r.status = scan_free(len, found);
                if (r.status == vrt_pkg::STATUS_OK)
                    r.found = found;
            end
        endcase
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        region_result_t want;
        if (!aresetn) begin
            for (int s = 0; s < ENTRIES; s++)
                kind_q[s] = vrt_pkg::KIND_FREE;
            merge_en_q = 1'b1;
            scan_lo_q  = vrt_pkg::SEARCH_START_RST;
            scan_hi_q  = vrt_pkg::SEARCH_END_RST;
            pending_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    vrt_pkg::CFG_MERGE_EN:     merge_en_q = cfg_wdata[0];
                    vrt_pkg::CFG_SEARCH_START: scan_lo_q  = cfg_wdata;
                    vrt_pkg::CFG_SEARCH_END:   scan_hi_q  = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report("unexpected result status", 32'(m_status), 32'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_status != want.status)
                        report("status", 32'(m_status), 32'(want.status));
                    if (m_slot != want.slot)
                        report("slot", 32'(m_slot), 32'(want.slot));
                    if (m_found_address != want.found)
                        report("found_address", m_found_address, want.found);
                end
            end
            if (s_valid && s_ready)
                pending_results.push_back(predict_request(vrt_pkg::func_t'(s_func),
                    s_address, s_length, s_perm, s_header_ref, s_binary_ref));
        end
        outstanding = pending_results.size();
    end

endmodule

// ===== sim/virtual_region_table_core_tb.sv =====
// Stimulus and verdict for the region table engine. The checker beside the
// block keeps its own table copy and scores every result transfer.
module virtual_region_table_core_tb;

    localparam logic [31:0] WIN  = 32'h0080_0000;   // base of the busy address window
    localparam logic [31:0] PAGE = 32'h0000_1000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = vrt_pkg::CFG_MERGE_EN;
    logic [31:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = vrt_pkg::FUNC_LOOKUP;
    logic [31:0] s_address = '0;
    logic [31:0] s_length = '0;
    logic [11:0] s_perm = '0;
    logic [31:0] s_header_ref = '0;
    logic [31:0] s_binary_ref = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [5:0]  m_slot;
    logic [31:0] m_found_address;
    int          errors;
    int          outstanding;

    int send_idle_pct = 0;   // chance per cycle that the sender holds back
    int recv_idle_pct = 0;   // chance per cycle that the receiver stalls

    virtual_region_table_core uut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_func, .s_address, .s_length, .s_perm,
        .s_header_ref, .s_binary_ref,
        .m_valid, .m_ready, .m_status, .m_slot, .m_found_address
    );

    virtual_region_table_checker chk (
        .aclk, .aresetn, .cfg_wr_en, .cfg_index, .cfg_wdata,
        .s_valid, .s_ready, .s_func, .s_address, .s_length, .s_perm,
        .s_header_ref, .s_binary_ref,
        .m_valid, .m_ready, .m_status, .m_slot, .m_found_address,
        .errors, .outstanding
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver stalls, redrawn every falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Sends one transfer. s_ready is stable between rising edges, so it is read
    // at the falling edge ahead of the edge that would take the transfer.
    task automatic send(vrt_pkg::func_t f, logic [31:0] addr, logic [31:0] len,
                        logic [11:0] perm, logic [31:0] htag, logic [31:0] btag);
        logic taken;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct)
                @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_address    <= addr;
        s_length     <= len;
        s_perm       <= perm;
        s_header_ref <= htag;
        s_binary_ref <= btag;
        do begin
            taken = s_ready;
            @(negedge aclk);
        end while (!taken);
    endtask

    // Hold the sender off until every result is back.
    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Mostly well-formed traffic in a 64-page window so regions get hit,
    // trimmed, split and merged; a few fully random transfers as noise.
    task automatic random_request();
        int r;
        logic [31:0] addr, len, btag;
        logic [11:0] perm;
        r    = $urandom_range(99);
        addr = WIN + ($urandom_range(63) << 12);
        if ($urandom_range(7) == 0)
            addr = addr + $urandom_range(4095);
        len = $urandom_range(1, 8) << 12;
        if ($urandom_range(7) == 0)
            len = len - $urandom_range(4095);
        perm = 12'($urandom_range(3));
        btag = $urandom_range(1) ? 32'h0 : 32'($urandom_range(1, 3));
        if (r < 6) begin
            r = $urandom_range(3);
            if (vrt_pkg::func_t'(r) == vrt_pkg::FUNC_INSERT)
                send(vrt_pkg::FUNC_INSERT, addr, $urandom_range(1, 65535), 12'($urandom),
                     $urandom, $urandom);
            else
                send(vrt_pkg::func_t'(r), $urandom, $urandom, 12'($urandom), $urandom,
                     $urandom);
        end else if (r < 38) begin
            send(vrt_pkg::FUNC_INSERT, addr, len, perm, $urandom, btag);
        end else if (r < 68) begin
            send(vrt_pkg::FUNC_REMOVE, addr, $urandom_range(1, 4) << 12, perm, $urandom,
                 btag);
        end else if (r < 85) begin
            send(vrt_pkg::FUNC_LOOKUP, addr + $urandom_range(4095), len, perm, $urandom,
                 btag);
        end else begin
            send(vrt_pkg::FUNC_FIND, addr, 32'($urandom_range(0, 20 * 4096)), perm,
                 $urandom, btag);
        end
    endtask

    initial begin
        #1_000_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: corner cases against the reset configuration
        send(vrt_pkg::FUNC_INSERT, WIN, 32'd1, 12'h000, 32'h0, 32'h0);        // one byte, anon
        send(vrt_pkg::FUNC_INSERT, WIN + PAGE, 3 * PAGE, 12'hFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF);
        send(vrt_pkg::FUNC_INSERT, WIN, 32'd0, 12'h0, 32'h0, 32'h0);          // zero length
        send(vrt_pkg::FUNC_LOOKUP, WIN + 2 * PAGE, 32'd0, 12'h0, 32'h0, 32'h0); // hit
        send(vrt_pkg::FUNC_LOOKUP, 32'h0, 32'd0, 12'h0, 32'h0, 32'h0);        // miss
        send(vrt_pkg::FUNC_REMOVE, WIN + PAGE, 32'd0, 12'h0, 32'h0, 32'h0);   // zero length
        send(vrt_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, PAGE, 12'h0, 32'h0, 32'h0); // nothing there
        send(vrt_pkg::FUNC_REMOVE, WIN + PAGE, 5 * PAGE, 12'h0, 32'h0, 32'h0); // past end
        send(vrt_pkg::FUNC_REMOVE, WIN + PAGE, 32'd16, 12'h0, 32'h0, 32'h0);  // trim front
        send(vrt_pkg::FUNC_REMOVE, WIN + 4 * PAGE - 16, 32'd16, 12'h0, 32'h0,
             32'h0);                                                           // trim back
        send(vrt_pkg::FUNC_REMOVE, WIN + 2 * PAGE, PAGE, 12'h0, 32'h0, 32'h0); // split
        send(vrt_pkg::FUNC_FIND, 32'h0, 32'd0, 12'h0, 32'h0, 32'h0);          // zero: a page
        send(vrt_pkg::FUNC_FIND, 32'h0, PAGE + 1, 12'h0, 32'h0, 32'h0);       // rounds up
        // adjacent same-kind regions merge
        send(vrt_pkg::FUNC_INSERT, WIN + 8 * PAGE, PAGE, 12'h001, 32'h5, 32'h0);
        send(vrt_pkg::FUNC_INSERT, WIN + 9 * PAGE, PAGE, 12'h001, 32'h6, 32'h0);
        send(vrt_pkg::FUNC_INSERT, WIN + 7 * PAGE, PAGE, 12'h001, 32'h7, 32'h0);
        // region ending exactly at the top of the address space
        send(vrt_pkg::FUNC_INSERT, 32'hFFFF_F000, 32'h0000_1000, 12'h0, 32'h0, 32'h1);
        send(vrt_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0, 12'h0, 32'h0, 32'h0);
        // neighbors whose summed length overflows stay apart
        send(vrt_pkg::FUNC_INSERT, 32'h0, 32'hFFFF_F000, 12'h0, 32'h0, 32'h1);
        send(vrt_pkg::FUNC_LOOKUP, 32'hFFFF_EFFF, 32'h0, 12'h0, 32'h0, 32'h0);
        send(vrt_pkg::FUNC_REMOVE, 32'h0, 32'hFFFF_F000, 12'h0, 32'h0, 32'h0);
        send(vrt_pkg::FUNC_REMOVE, 32'hFFFF_F000, 32'h0000_1000, 12'h0, 32'h0, 32'h0);
        drain();

        // empty search window: no space
        cfg_write(vrt_pkg::CFG_SEARCH_START, 32'hFFFF_FFFF);
        cfg_write(vrt_pkg::CFG_SEARCH_END, 32'h0);
        send(vrt_pkg::FUNC_FIND, 32'h0, 32'h0, 12'h0, 32'h0, 32'h0);
        drain();

        // fill every slot with unmergeable regions, then free them again
        cfg_write(vrt_pkg::CFG_MERGE_EN, 32'h0);
        for (int i = 0; i < 65; i++)
            send(vrt_pkg::FUNC_INSERT, 32'h4000_0000 + i * 2 * PAGE, PAGE, 12'(i), 32'(i),
                 32'h0);
        send(vrt_pkg::FUNC_REMOVE, 32'h4000_0000 + 16, 32'd16, 12'h0, 32'h0,
             32'h0);                                                           // split, full
        send(vrt_pkg::FUNC_FIND, 32'h0, PAGE, 12'h0, 32'h0, 32'h0);
        for (int i = 0; i < 64; i++)
            send(vrt_pkg::FUNC_REMOVE, 32'h4000_0000 + i * 2 * PAGE, PAGE, 12'h0, 32'h0,
                 32'h0);
        drain();

        // three random phases, each with its own register setting and idling mix
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    cfg_write(vrt_pkg::CFG_MERGE_EN, 32'h1);
                    cfg_write(vrt_pkg::CFG_SEARCH_START, vrt_pkg::SEARCH_START_RST);
                    cfg_write(vrt_pkg::CFG_SEARCH_END, vrt_pkg::SEARCH_END_RST);
                    send_idle_pct = 23;
                    recv_idle_pct = 70;
                end
                1: begin
                    cfg_write(vrt_pkg::CFG_MERGE_EN, 32'h0);
                    cfg_write(vrt_pkg::CFG_SEARCH_START, 32'h0);
                    cfg_write(vrt_pkg::CFG_SEARCH_END, 32'hFFFF_FFFF);
                    send_idle_pct = 70;
                    recv_idle_pct = 23;
                end
                default: begin
                    cfg_write(vrt_pkg::CFG_MERGE_EN, 32'h1);
                    cfg_write(vrt_pkg::CFG_SEARCH_START, WIN);
                    cfg_write(vrt_pkg::CFG_SEARCH_END, WIN + 32'h0004_0000);
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 620; n++) begin
                random_request();
                if (phase == 0 && n == 300)
                    drain();
            end
            drain();
        end

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/vrt_pkg.sv
design/virtual_region_table_core.sv
design/vrt_checker.sv
sim/virtual_region_table_checker.sv
sim/virtual_region_table_core_tb.sv
